// ===== sv/arm64_instruction_relocator_core_defines.svh =====
// Assertion macros shared by the relocator RTL.
`ifndef ARM64_INSTRUCTION_RELOCATOR_CORE_DEFINES_SVH
`define ARM64_INSTRUCTION_RELOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ARIR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arir: implication check failed");
`define ARIR_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("arir: forbidden condition seen");
`else
`define ARIR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ARIR_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== sv/arir_pkg.sv =====
// Package with the encodings, types and helpers of the instruction relocator.
`timescale 1ns / 1ps
package arir_pkg;

    localparam int DEF_MAX_RELOC_BYTES = 24;
    localparam int MAX_WORDS = 6;
    localparam int WORD_CNT_W = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_FILL_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    localparam logic [31:0] OP_LDR_LIT64 = 32'h5800_0000;
    localparam logic [31:0] OP_B         = 32'h1400_0000;
    localparam logic [31:0] OP_BR        = 32'hD61F_0000;
    localparam logic [31:0] OP_BLR       = 32'hD63F_0000;
    localparam logic [31:0] OP_NOP       = 32'hD503_201F;
    localparam logic [31:0] OP_LDR_W     = 32'hB940_0000;
    localparam logic [31:0] OP_LDR_X     = 32'hF940_0000;
    localparam logic [31:0] OP_LDRSW     = 32'hB980_0000;
    localparam logic [31:0] OP_LDR_S     = 32'hBD40_0000;
    localparam logic [31:0] OP_LDR_D     = 32'hFD40_0000;
    localparam logic [31:0] OP_LDR_Q     = 32'h3DC0_0000;
    localparam logic [31:0] OP_BCOND     = 32'h5400_0000;

    localparam logic [31:0] MASK_ADR   = 32'h1F00_0000;
    localparam logic [31:0] MATCH_ADR  = 32'h1000_0000;
    localparam logic [31:0] MASK_B     = 32'h7C00_0000;
    localparam logic [31:0] MATCH_B    = 32'h1400_0000;
    localparam logic [31:0] MASK_BCOND = 32'hFF00_0010;
    localparam logic [31:0] MASK_CMPB  = 32'h7E00_0000;
    localparam logic [31:0] MATCH_CB   = 32'h3400_0000;
    localparam logic [31:0] MATCH_TB   = 32'h3600_0000;
    localparam logic [31:0] MASK_LIT   = 32'h3B00_0000;
    localparam logic [31:0] MATCH_LIT  = 32'h1800_0000;

    localparam logic [4:0] REG_JUMP = 5'd16;
    localparam logic [4:0] REG_LOAD = 5'd17;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNRELOC  = 2'd1,
        ST_CAPACITY = 2'd2,
        ST_FAILED   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CL_ADR    = 3'd0,
        CL_BRANCH = 3'd1,
        CL_COND   = 3'd2,
        CL_TEST   = 3'd3,
        CL_LIT    = 3'd4,
        CL_COPY   = 3'd5
    } class_t;

    typedef struct packed {
        logic [MAX_WORDS-1:0][31:0] words;
        logic [WORD_CNT_W-1:0]      count;
        status_t                    status;
        logic [15:0]                bytes_total;
    } entry_t;

    function automatic logic [31:0] enc_ldr_lit(input logic [4:0] rt, input logic [31:0] off);
        return OP_LDR_LIT64 | {8'h00, off[20:2], rt};
    endfunction

    function automatic logic [31:0] enc_b(input logic [31:0] off);
        return OP_B | {6'h00, off[27:2]};
    endfunction

endpackage

// ===== sv/arir_in_if.sv =====
// Interface of the instruction input channel.
`timescale 1ns / 1ps
interface arir_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic [63:0] instr_pc;
    logic        final_instr;

    modport source (output valid, output instr_word, output instr_pc, output final_instr,
                    input ready);
    modport sink (input valid, input instr_word, input instr_pc, input final_instr,
                  output ready);
endinterface

// ===== sv/arir_out_if.sv =====
// Interface of the replacement word output channel.
`timescale 1ns / 1ps
interface arir_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        word_last;
    logic [1:0]  status;
    logic [15:0] bytes_total;

    modport source (output valid, output out_word, output word_last, output status,
                    output bytes_total, input ready);
    modport sink (input valid, input out_word, input word_last, input status,
                  input bytes_total, output ready);
endinterface

// ===== sv/arir_cfg_if.sv =====
// Interface of the capacity register write channel.
`timescale 1ns / 1ps
interface arir_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_capacity;

    modport source (output valid, output out_capacity, input ready);
    modport sink (input valid, input out_capacity, output ready);
endinterface

// ===== sv/arir_front.sv =====
// Front end: accepts instructions, classifies them and builds the replacement words.
`timescale 1ns / 1ps
module arir_front
    import arir_pkg::*;
#(
    parameter int MAX_RELOC_BYTES = DEF_MAX_RELOC_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    arir_in_if.sink    instr,
    arir_cfg_if.sink   cfg,
    input  logic       q_full,
    output logic       push,
    output entry_t     push_entry
);

    logic [15:0] capacity_reg;
    logic [15:0] bytes_written_reg;
    logic [15:0] bytes_written_next;
    logic        run_failed_reg;
    logic        run_failed_next;

    class_t                     cls;
    logic [31:0]                iw;
    logic [63:0]                offset;
    logic [63:0]                base;
    logic [63:0]                target;
    logic [MAX_WORDS-1:0][31:0] words;
    logic [WORD_CNT_W-1:0]      count;
    logic [31:0]                load_op;
    logic                       unreloc;
    logic                       over_cap;
    status_t                    status;
    logic [15:0]                bytes_new;

    assign iw         = instr.instr_word;
    assign instr.ready = !q_full;
    assign cfg.ready   = 1'b1;
    assign push        = instr.valid && instr.ready;

    always_comb
    begin
        if ((iw & MASK_ADR) == MATCH_ADR)
        begin
            cls = CL_ADR;
        end
        else if ((iw & MASK_B) == MATCH_B)
        begin
            cls = CL_BRANCH;
        end
        else if ((iw & MASK_BCOND) == OP_BCOND || (iw & MASK_CMPB) == MATCH_CB)
        begin
            cls = CL_COND;
        end
        else if ((iw & MASK_CMPB) == MATCH_TB)
        begin
            cls = CL_TEST;
        end
        else if ((iw & MASK_LIT) == MATCH_LIT)
        begin
            cls = CL_LIT;
        end
        else
        begin
            cls = CL_COPY;
        end
    end

    always_comb
    begin
        case (cls)
            CL_ADR:
            begin
                if (iw[31])
                begin
                    offset = {{31{iw[23]}}, iw[23:5], iw[30:29], 12'h000};
                end
                else
                begin
                    offset = {{43{iw[23]}}, iw[23:5], iw[30:29]};
                end
            end
            CL_BRANCH: offset = {{36{iw[25]}}, iw[25:0], 2'b00};
            CL_COND:   offset = {{43{iw[23]}}, iw[23:5], 2'b00};
            CL_LIT:    offset = {{43{iw[23]}}, iw[23:5], 2'b00};
            CL_TEST:   offset = {{48{iw[18]}}, iw[18:5], 2'b00};
            default:   offset = 64'h0;
        endcase
        base   = (cls == CL_ADR && iw[31]) ? {instr.instr_pc[63:12], 12'h000}
                                           : instr.instr_pc;
        target = base + offset;
    end

    always_comb
    begin
        case ({iw[26], iw[31:30]})
            3'b000:  load_op = OP_LDR_W;
            3'b001:  load_op = OP_LDR_X;
            3'b010:  load_op = OP_LDRSW;
            3'b100:  load_op = OP_LDR_S;
            3'b101:  load_op = OP_LDR_D;
            3'b110:  load_op = OP_LDR_Q;
            default: load_op = OP_NOP;
        endcase
    end

    always_comb
    begin
        words   = '0;
        count   = WORD_CNT_W'(1);
        unreloc = 1'b0;
        case (cls)
            CL_ADR:
            begin
                words[0] = enc_ldr_lit(iw[4:0], 32'd8);
                words[1] = enc_b(32'd12);
                words[2] = target[31:0];
                words[3] = target[63:32];
                count    = WORD_CNT_W'(4);
            end
            CL_BRANCH:
            begin
                if (iw[31])
                begin
                    words[0] = enc_ldr_lit(REG_JUMP, 32'd12);
                    words[1] = OP_BLR | {22'h0, REG_JUMP, 5'h00};
                    words[2] = enc_b(32'd12);
                    words[3] = target[31:0];
                    words[4] = target[63:32];
                    count    = WORD_CNT_W'(5);
                end
                else
                begin
                    words[0] = enc_ldr_lit(REG_JUMP, 32'd8);
                    words[1] = OP_BR | {22'h0, REG_JUMP, 5'h00};
                    words[2] = target[31:0];
                    words[3] = target[63:32];
                    count    = WORD_CNT_W'(4);
                end
            end
            CL_COND, CL_TEST:
            begin
                if (cls == CL_COND)
                begin
                    words[0] = {iw[31:24], 19'd2, iw[4:0]};
                end
                else
                begin
                    words[0] = {iw[31:19], 14'd2, iw[4:0]};
                end
                words[1] = enc_b(32'd20);
                words[2] = enc_ldr_lit(REG_JUMP, 32'd8);
                words[3] = OP_BR | {22'h0, REG_JUMP, 5'h00};
                words[4] = target[31:0];
                words[5] = target[63:32];
                count    = WORD_CNT_W'(6);
            end
            CL_LIT:
            begin
                if (iw[31:30] == 2'b11)
                begin
                    words[0] = OP_NOP;
                    unreloc  = iw[26];
                end
                else
                begin
                    words[0] = enc_ldr_lit(REG_LOAD, 32'd8);
                    words[1] = enc_b(32'd12);
                    words[2] = target[31:0];
                    words[3] = target[63:32];
                    words[4] = load_op | {22'h0, REG_LOAD, iw[4:0]};
                    count    = WORD_CNT_W'(5);
                end
            end
            default:
            begin
                words[0] = iw;
            end
        endcase
    end

    always_comb
    begin
        over_cap = ({1'b0, bytes_written_reg} + 17'(MAX_RELOC_BYTES)) > {1'b0, capacity_reg};
        if (run_failed_reg)
        begin
            status = ST_FAILED;
        end
        else if (over_cap)
        begin
            status = ST_CAPACITY;
        end
        else if (unreloc)
        begin
            status = ST_UNRELOC;
        end
        else
        begin
            status = ST_OK;
        end
        bytes_new = bytes_written_reg + {11'h000, count, 2'b00};

        push_entry.status = status;
        if (status == ST_OK)
        begin
            push_entry.words       = words;
            push_entry.count       = count;
            push_entry.bytes_total = bytes_new;
        end
        else
        begin
            push_entry.words       = '0;
            push_entry.count       = WORD_CNT_W'(1);
            push_entry.bytes_total = bytes_written_reg;
        end

        bytes_written_next = bytes_written_reg;
        run_failed_next    = run_failed_reg;
        if (push)
        begin
            if (instr.final_instr)
            begin
                bytes_written_next = 16'h0000;
                run_failed_next    = 1'b0;
            end
            else if (status != ST_OK)
            begin
                run_failed_next = 1'b1;
            end
            else
            begin
                bytes_written_next = bytes_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg      <= CAPACITY_RESET;
            bytes_written_reg <= 16'h0000;
            run_failed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                capacity_reg <= cfg.out_capacity;
            end
            bytes_written_reg <= bytes_written_next;
            run_failed_reg    <= run_failed_next;
        end
    end

endmodule

// ===== sv/arir_queue.sv =====
// Short queue of relocated entries between the front end and the word emitter.
`timescale 1ns / 1ps
`include "arm64_instruction_relocator_core_defines.svh"
module arir_queue
    import arir_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   head_valid
);

    entry_t                  entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [QUEUE_FILL_W-1:0] fill_reg;

    assign full       = fill_reg == QUEUE_FILL_W'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head       = entries_reg[rd_ptr_reg];

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + QUEUE_FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - QUEUE_FILL_W'(1);
            end
        end
    end

    `ARIR_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)
    `ARIR_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && !head_valid)
    `ARIR_ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= QUEUE_FILL_W'(QUEUE_DEPTH))

endmodule

// ===== sv/arir_back.sv =====
// Back end: emits the words of the head entry one per cycle while result is ready, through an output register.
`timescale 1ns / 1ps
`include "arm64_instruction_relocator_core_defines.svh"
module arir_back
    import arir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        head_valid,
    output logic        pop,
    arir_out_if.source  result
);

    logic [WORD_CNT_W-1:0] idx_reg;
    logic                  out_valid_reg;
    logic [31:0]           out_word_reg;
    logic                  word_last_reg;
    logic [1:0]            status_reg;
    logic [15:0]           bytes_total_reg;
    logic                  load;
    logic                  at_last;

    assign load    = head_valid && (!out_valid_reg || result.ready);
    assign at_last = (idx_reg + WORD_CNT_W'(1)) == head.count;
    assign pop     = load && at_last;

    assign result.valid       = out_valid_reg;
    assign result.out_word    = out_word_reg;
    assign result.word_last   = word_last_reg;
    assign result.status      = status_reg;
    assign result.bytes_total = bytes_total_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg    <= head.words[idx_reg];
            word_last_reg   <= at_last;
            status_reg      <= head.status;
            bytes_total_reg <= head.bytes_total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? '0 : idx_reg + WORD_CNT_W'(1);
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ARIR_ASSERT_IMPLIES(a_idx_in_entry, clk, rst_n, head_valid, idx_reg < head.count)
    `ARIR_ASSERT_IMPLIES(a_idx_idle_zero, clk, rst_n, !head_valid, idx_reg == '0)
    `ARIR_ASSERT_IMPLIES(a_fail_single, clk, rst_n, out_valid_reg && status_reg != ST_OK,
                         word_last_reg && out_word_reg == 32'h0)

endmodule

// ===== sv/arm64_instruction_relocator_core.sv =====
// Top level of the AArch64 instruction relocator.
//
//   Channel  Role    Payload
//   instr    sink    instr_word, instr_pc, final_instr
//   result   source  out_word, word_last, status, bytes_total
//   cfg      sink    out_capacity
//
// An instruction is accepted whenever the two-entry queue has room.
// Its one to six words leave on result at one word per cycle while result is ready;
// each word passes through the queue entry and then the output register.
// A stall on result fills the queue and then drops instr.ready; cfg is always ready.
// Reset clears the byte count, the failure flag and the queue, and sets capacity to 4096.
`timescale 1ns / 1ps
module arm64_instruction_relocator_core
    import arir_pkg::*;
#(
    parameter int MAX_RELOC_BYTES = DEF_MAX_RELOC_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    arir_in_if.sink    instr,
    arir_out_if.source result,
    arir_cfg_if.sink   cfg
);

    logic   push;
    entry_t push_entry;
    logic   q_full;
    logic   pop;
    entry_t head;
    logic   head_valid;

    arir_front #(
        .MAX_RELOC_BYTES(MAX_RELOC_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .instr     (instr),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_entry(push_entry)
    );

    arir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .head_valid(head_valid)
    );

    arir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .head_valid(head_valid),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== tb/reloc_check.sv =====
// Checker that predicts the relocator's replacement words and compares them with the result channel.
`timescale 1ns / 1ps
module reloc_check
    import arir_pkg::*;
#(
    parameter int MAX_RELOC_BYTES = DEF_MAX_RELOC_BYTES
) (
    input  logic clk,
    input  logic rst_n,
    arir_in_if   instr,
    arir_out_if  result,
    arir_cfg_if  cfg,
    output int   mismatches,
    output int   pending
);

    typedef struct {
        logic [31:0] word;
        logic        last;
        status_t     status;
        logic [15:0] total;
    } reloc_word_t;

    reloc_word_t expected_words[$];
    logic [15:0] capacity;
    logic [15:0] bytes_written;
    logic        run_failed;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [31:0] ldr_x_literal(input logic [4:0] rt, input int unsigned byte_off);
        return OP_LDR_LIT64 | {8'h00, 19'(byte_off / 4), rt};
    endfunction

    function automatic logic [31:0] branch_ahead(input int unsigned byte_off);
        return OP_B | {6'h00, 26'(byte_off / 4)};
    endfunction

    // Returns the number of replacement words, zero when the item cannot be relocated.
    function automatic int relocate_words(input logic [31:0] insn, input logic [63:0] pc,
                                          output logic [5:0][31:0] w);
        logic [63:0] imm;
        logic [63:0] target;
        logic [31:0] load_op;
        logic [1:0]  opc;
        logic        simd;
        logic [31:0] jump_br;
        w = '0;
        jump_br = OP_BR | (32'(REG_JUMP) << 5);
        if ((insn & MASK_ADR) == MATCH_ADR)
        begin
            imm = {{43{insn[23]}}, insn[23:5], insn[30:29]};
            target = insn[31] ? ((pc & ~64'hFFF) + (imm << 12)) : (pc + imm);
            w[0] = ldr_x_literal(insn[4:0], 8);
            w[1] = branch_ahead(12);
            w[2] = target[31:0];
            w[3] = target[63:32];
            return 4;
        end
        if ((insn & MASK_B) == MATCH_B)
        begin
            target = pc + {{36{insn[25]}}, insn[25:0], 2'b00};
            if (!insn[31])
            begin
                w[0] = ldr_x_literal(REG_JUMP, 8);
                w[1] = jump_br;
                w[2] = target[31:0];
                w[3] = target[63:32];
                return 4;
            end
            w[0] = ldr_x_literal(REG_JUMP, 12);
            w[1] = OP_BLR | (32'(REG_JUMP) << 5);
            w[2] = branch_ahead(12);
            w[3] = target[31:0];
            w[4] = target[63:32];
            return 5;
        end
        if ((insn & MASK_BCOND) == OP_BCOND || (insn & MASK_CMPB) == MATCH_CB
            || (insn & MASK_CMPB) == MATCH_TB)
        begin
            if ((insn & MASK_CMPB) == MATCH_TB)
            begin
                target = pc + {{48{insn[18]}}, insn[18:5], 2'b00};
                w[0] = {insn[31:19], 14'd2, insn[4:0]};
            end
            else
            begin
                target = pc + {{43{insn[23]}}, insn[23:5], 2'b00};
                w[0] = {insn[31:24], 19'd2, insn[4:0]};
            end
            w[1] = branch_ahead(20);
            w[2] = ldr_x_literal(REG_JUMP, 8);
            w[3] = jump_br;
            w[4] = target[31:0];
            w[5] = target[63:32];
            return 6;
        end
        if ((insn & MASK_LIT) == MATCH_LIT)
        begin
            opc = insn[31:30];
            simd = insn[26];
            target = pc + {{43{insn[23]}}, insn[23:5], 2'b00};
            if (opc == 2'd3 && !simd)
            begin
                w[0] = OP_NOP;
                return 1;
            end
            if (opc == 2'd3)
            begin
                return 0;
            end
            if (simd)
            begin
                load_op = (opc == 2'd0) ? OP_LDR_S : (opc == 2'd1) ? OP_LDR_D : OP_LDR_Q;
            end
            else
            begin
                load_op = (opc == 2'd0) ? OP_LDR_W : (opc == 2'd1) ? OP_LDR_X : OP_LDRSW;
            end
            w[0] = ldr_x_literal(REG_LOAD, 8);
            w[1] = branch_ahead(12);
            w[2] = target[31:0];
            w[3] = target[63:32];
            w[4] = load_op | (32'(REG_LOAD) << 5) | 32'(insn[4:0]);
            return 5;
        end
        w[0] = insn;
        return 1;
    endfunction

    task automatic predict_replacement(input logic [31:0] insn, input logic [63:0] pc,
                                       input logic last_of_run);
        logic [5:0][31:0] w;
        int               n;
        status_t          st;
        reloc_word_t      e;
        n = 0;
        st = ST_OK;
        if (run_failed)
        begin
            st = ST_FAILED;
        end
        else if (int'(bytes_written) + MAX_RELOC_BYTES > int'(capacity))
        begin
            st = ST_CAPACITY;
        end
        else
        begin
            n = relocate_words(insn, pc, w);
            if (n == 0)
            begin
                st = ST_UNRELOC;
            end
        end
        if (st != ST_OK)
        begin
            run_failed = 1'b1;
            e.word = '0;
            e.last = 1'b1;
            e.status = st;
            e.total = bytes_written;
            expected_words.push_back(e);
        end
        else
        begin
            bytes_written = bytes_written + 16'(4 * n);
            for (int k = 0; k < n; k++)
            begin
                e.word = w[k];
                e.last = (k == n - 1);
                e.status = ST_OK;
                e.total = bytes_written;
                expected_words.push_back(e);
            end
        end
        if (last_of_run)
        begin
            bytes_written = '0;
            run_failed = 1'b0;
        end
    endtask

    task automatic check_word();
        reloc_word_t e;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %h", result.out_word));
            return;
        end
        e = expected_words.pop_front();
        if (result.out_word !== e.word)
        begin
            report_mismatch($sformatf("out_word %h, expected %h", result.out_word, e.word));
        end
        if (result.word_last !== e.last)
        begin
            report_mismatch($sformatf("word_last %b, expected %b", result.word_last, e.last));
        end
        if (result.status !== e.status)
        begin
            report_mismatch($sformatf("status %0d, expected %0d", result.status, e.status));
        end
        if (result.bytes_total !== e.total)
        begin
            report_mismatch($sformatf("bytes_total %0d, expected %0d",
                                      result.bytes_total, e.total));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = CAPACITY_RESET;
            bytes_written = '0;
            run_failed = 1'b0;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                capacity = cfg.out_capacity;
            end
            if (result.valid && result.ready)
            begin
                check_word();
            end
            if (instr.valid && instr.ready)
            begin
                predict_replacement(instr.instr_word, instr.instr_pc, instr.final_instr);
            end
            pending <= expected_words.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the relocator testbench: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module testbench
    import arir_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   cycle_count;
    int   hold_left;
    bit   gaps_on;
    bit   stalls_on;
    bit   squeeze;
    bit   squeeze_done;

    arir_in_if  instr();
    arir_out_if result();
    arir_cfg_if cfg();

    arm64_instruction_relocator_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr),
        .result (result),
        .cfg    (cfg)
    );

    reloc_check reloc_check_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr),
        .result     (result),
        .cfg        (cfg),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The receiver stalls at random; a squeeze request holds it off long enough to back up the input.
    always @(posedge clk)
    begin
        if (squeeze && !squeeze_done)
        begin
            squeeze_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result.ready <= 1'b0;
        end
        else if (stalls_on)
        begin
            result.ready <= ($urandom_range(0, 99) >= 30);
        end
        else
        begin
            result.ready <= 1'b1;
        end
    end

    function automatic logic [31:0] adr_word(input logic page, input logic [20:0] imm,
                                             input logic [4:0] rd);
        return MATCH_ADR | {page, imm[1:0], 5'd0, imm[20:2], rd};
    endfunction

    function automatic logic [31:0] branch_word(input logic link, input logic [25:0] imm);
        return MATCH_B | {link, 5'd0, imm};
    endfunction

    function automatic logic [31:0] cond_word(input logic [18:0] imm, input logic [3:0] cond);
        return OP_BCOND | {8'd0, imm, 1'b0, cond};
    endfunction

    function automatic logic [31:0] cb_word(input logic sf, input logic nz,
                                            input logic [18:0] imm, input logic [4:0] rt);
        return MATCH_CB | {sf, 6'd0, nz, imm, rt};
    endfunction

    function automatic logic [31:0] tb_word(input logic b5, input logic nz, input logic [4:0] b40,
                                            input logic [13:0] imm, input logic [4:0] rt);
        return MATCH_TB | {b5, 6'd0, nz, b40, imm, rt};
    endfunction

    function automatic logic [31:0] lit_word(input logic [1:0] opc, input logic simd,
                                             input logic [18:0] imm, input logic [4:0] rt);
        return MATCH_LIT | {opc, 3'd0, simd, 2'd0, imm, rt};
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [1:0] opc;
        logic       simd;
        opc = 2'($urandom);
        simd = (opc == 2'd3) ? ($urandom_range(0, 15) == 0) : 1'($urandom);
        case ($urandom_range(0, 9))
            0: return adr_word(1'($urandom), 21'($urandom), 5'($urandom));
            1: return branch_word(1'($urandom), 26'($urandom));
            2: return cond_word(19'($urandom), 4'($urandom));
            3: return cb_word(1'($urandom), 1'($urandom), 19'($urandom), 5'($urandom));
            4: return tb_word(1'($urandom), 1'($urandom), 5'($urandom), 14'($urandom),
                              5'($urandom));
            5, 6: return lit_word(opc, simd, 19'($urandom), 5'($urandom));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand_pc();
        case ($urandom_range(0, 7))
            0: return 64'($urandom_range(0, 4095));
            1: return ~64'($urandom_range(0, 4095));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_item(input logic [31:0] word, input logic [63:0] pc, input logic fin);
        if (gaps_on && $urandom_range(0, 99) < 30)
        begin
            instr.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        instr.valid <= 1'b1;
        instr.instr_word <= word;
        instr.instr_pc <= pc;
        instr.final_instr <= fin;
        do @(posedge clk); while (!instr.ready);
    endtask

    task automatic send_random(input int count, input int run_len);
        for (int i = 0; i < count; i++)
        begin
            send_item(rand_instr(), rand_pc(), $urandom_range(0, run_len - 1) == 0);
        end
    endtask

    task automatic settle();
        instr.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.out_capacity <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        instr.valid = 1'b0;
        instr.instr_word = '0;
        instr.instr_pc = '0;
        instr.final_instr = 1'b0;
        cfg.valid = 1'b0;
        cfg.out_capacity = '0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        squeeze = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_item(adr_word(1'b0, 21'h0FFFFF, 5'd5), 64'h0, 1'b0);
        send_item(adr_word(1'b0, 21'h100000, 5'd31), '1, 1'b0);
        send_item(adr_word(1'b1, 21'h1FFFFF, 5'd0), 64'h1234_5678_9ABC_DEF0, 1'b0);
        send_item(adr_word(1'b1, 21'h0FFFFF, 5'd9), 64'hFFFF_FFFF_FFFF_F000, 1'b0);
        send_item(branch_word(1'b0, 26'h1FFFFFF), 64'h8000, 1'b0);
        send_item(branch_word(1'b0, 26'h3FFFFFF), 64'h0, 1'b0);
        send_item(branch_word(1'b1, 26'h2000000), 64'hFEDC_BA98_7654_3210, 1'b0);
        send_item(cond_word(19'h40000, 4'hE), 64'h1000, 1'b0);
        send_item(OP_BCOND | 32'h10, 64'h1000, 1'b0);
        send_item(cb_word(1'b1, 1'b0, 19'd1, 5'd3), rand_pc(), 1'b0);
        send_item(cb_word(1'b0, 1'b1, 19'h7FFFF, 5'd7), rand_pc(), 1'b0);
        send_item(tb_word(1'b0, 1'b0, 5'd31, 14'h2000, 5'd1), rand_pc(), 1'b0);
        send_item(tb_word(1'b1, 1'b1, 5'd31, 14'h3FFF, 5'd30), rand_pc(), 1'b0);
        for (int opc = 0; opc < 3; opc++)
        begin
            send_item(lit_word(2'(opc), 1'b0, 19'(opc * 19'h2AAAA), 5'd2), rand_pc(), 1'b0);
            send_item(lit_word(2'(opc), 1'b1, 19'h7FFFF, 5'(opc)), rand_pc(), 1'b0);
        end
        send_item(lit_word(2'd3, 1'b0, 19'd4, 5'd0), rand_pc(), 1'b0);
        send_item(OP_NOP, rand_pc(), 1'b0);
        send_item(32'hFFFF_FFFF, rand_pc(), 1'b1);
        // An unallocated SIMD literal fails the run until its last item.
        send_item(lit_word(2'd3, 1'b1, 19'd8, 5'd4), rand_pc(), 1'b0);
        send_item(OP_NOP, rand_pc(), 1'b1);
        send_item(32'h0000_0000, rand_pc(), 1'b0);
        settle();

        write_capacity(16'd0);
        send_item(OP_NOP, 64'h0, 1'b0);
        send_item(OP_NOP, 64'h0, 1'b1);
        settle();
        write_capacity(16'(DEF_MAX_RELOC_BYTES));
        send_item(cond_word(19'd5, 4'd1), 64'h4000, 1'b0);
        send_item(OP_NOP, 64'h4018, 1'b0);
        send_item(OP_NOP, 64'h401C, 1'b1);
        settle();

        write_capacity(16'hFFFF);
        send_random(150, 25);
        gaps_on = 1'b0;
        squeeze = 1'b1;
        send_random(30, 8);
        gaps_on = 1'b1;
        settle();

        write_capacity(16'd200);
        send_random(100, 10);
        settle();

        write_capacity(16'd4096);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_random(100, 15);
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        settle();

        write_capacity(16'($urandom_range(24, 400)));
        send_random(70, 8);
        settle();

        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
